// ----- hw/rtl/lobm_pkg.sv -----
package lobm_pkg;

  typedef struct packed {
    logic        command;
    logic        side;
    logic [15:0] quantity;
    logic [9:0]  price;
  } in_t;

  typedef struct packed {
    logic [9:0] best_ask;
    logic       ask_valid;
    logic [9:0] best_bid;
    logic       bid_valid;
    logic [9:0] last_trade_price;
    logic       trade_valid;
  } out_t;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic SIDE_BUY  = 1'b1;

endpackage

// ----- hw/rtl/limit_order_book_matcher.sv -----
// Channel | Dir | Handshake                     | Beat payload
// in      | in  | in_valid_i / in_ready_o       | lobm_pkg::in_t  (command, side, qty, price)
// out     | out | out_valid_o / out_ready_i     | lobm_pkg::out_t (best ask/bid, last trade)
//
// Place beat steps: accept, read, add, cross check, result; each trade adds a trade step and
//   another cross check; a best-price rescan reads one level per step, so cost tracks book depth.
// Clear beat and reset: a sweep writes zero to all PRICE_LEVELS entries of both RAMs;
//   in_ready_o stays low during the sweep.
// Stalls: one result register; the next beat is taken while a result waits, and its own
//   result is held back until the register frees up.
module limit_order_book_matcher #(
  parameter int PRICE_LEVELS   = 1024,
  parameter int LEVEL_QTY_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lobm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lobm_pkg::out_t out_data_o
);

  localparam int AW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
  localparam logic [AW-1:0] LastLevel = AW'(PRICE_LEVELS - 1);
  localparam logic [LEVEL_QTY_BITS-1:0] QtyMax = '1;

  // one-hot sequencer
  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001, // zero sweep over both books
    S_IDLE  = 11'b000_0000_0010,
    S_RD    = 11'b000_0000_0100, // read level at order price
    S_ADD   = 11'b000_0000_1000, // saturating add, write back
    S_MCHK  = 11'b000_0001_0000, // crossed? read both best levels
    S_TRADE = 11'b000_0010_0000,
    S_BRD   = 11'b000_0100_0000, // bid rescan, downward
    S_BCK   = 11'b000_1000_0000,
    S_ARD   = 11'b001_0000_0000, // ask rescan, upward
    S_ACK   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          res_pend_q, res_pend_d;   // clear sweep owes a result
  logic          side_q, side_d;
  logic [15:0]   qty_q, qty_d;
  logic [AW-1:0] price_q, price_d;
  logic [AW-1:0] bbest_q, bbest_d, abest_q, abest_d, ltrade_q, ltrade_d;
  logic          bpres_q, bpres_d, apres_q, apres_d, tseen_q, tseen_d;
  logic          ascan_q, ascan_d;         // ask rescan pending after bid rescan
  logic          ovalid_q, ovalid_d;
  lobm_pkg::out_t odata_q, odata_d;

  // level RAM ports
  logic                      bid_we, ask_we;
  logic [AW-1:0]             bid_addr, ask_addr;
  logic [LEVEL_QTY_BITS-1:0] bid_wdata, ask_wdata, bid_rdata, ask_rdata;

  logic                      in_ok;
  logic [LEVEL_QTY_BITS-1:0] old_qty, add_qty, trade_qty, bid_left, ask_left;
  logic [LEVEL_QTY_BITS:0]   sum;

  lobm_ram #(.Width(LEVEL_QTY_BITS), .Depth(PRICE_LEVELS)) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (bid_we),
    .addr_i  (bid_addr),
    .wdata_i (bid_wdata),
    .rdata_o (bid_rdata)
  );

  lobm_ram #(.Width(LEVEL_QTY_BITS), .Depth(PRICE_LEVELS)) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (ask_we),
    .addr_i  (ask_addr),
    .wdata_i (ask_wdata),
    .rdata_o (ask_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // price beyond the book or zero quantity: order is a no-op
  assign in_ok = (32'(in_data_i.price) < 32'(PRICE_LEVELS)) && (in_data_i.quantity != 16'd0);

  assign old_qty   = (side_q == lobm_pkg::SIDE_BUY) ? bid_rdata : ask_rdata;
  assign sum       = {1'b0, old_qty} + (LEVEL_QTY_BITS + 1)'(qty_q);
  assign add_qty   = sum[LEVEL_QTY_BITS] ? QtyMax : sum[LEVEL_QTY_BITS-1:0];
  assign trade_qty = (bid_rdata < ask_rdata) ? bid_rdata : ask_rdata;
  assign bid_left  = bid_rdata - trade_qty;
  assign ask_left  = ask_rdata - trade_qty;

  always_comb begin
    bid_we    = 1'b0;
    ask_we    = 1'b0;
    bid_addr  = bbest_q;
    ask_addr  = abest_q;
    bid_wdata = '0;
    ask_wdata = '0;
    unique case (state_q)
      S_CLR: begin
        bid_we   = 1'b1;
        ask_we   = 1'b1;
        bid_addr = clr_cnt_q;
        ask_addr = clr_cnt_q;
      end
      S_RD: begin
        bid_addr = price_q;
        ask_addr = price_q;
      end
      S_ADD: begin
        bid_addr  = price_q;
        ask_addr  = price_q;
        bid_we    = (side_q == lobm_pkg::SIDE_BUY);
        ask_we    = (side_q != lobm_pkg::SIDE_BUY);
        bid_wdata = add_qty;
        ask_wdata = add_qty;
      end
      S_TRADE: begin
        bid_we    = 1'b1;
        ask_we    = 1'b1;
        bid_wdata = bid_left;
        ask_wdata = ask_left;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    res_pend_d = res_pend_q;
    side_d     = side_q;
    qty_d      = qty_q;
    price_d    = price_q;
    bbest_d    = bbest_q;
    abest_d    = abest_q;
    bpres_d    = bpres_q;
    apres_d    = apres_q;
    ltrade_d   = ltrade_q;
    tseen_d    = tseen_q;
    ascan_d    = ascan_q;
    ovalid_d   = ovalid_q;
    odata_d    = odata_q;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastLevel) begin
          clr_cnt_d = '0;
          state_d   = res_pend_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          side_d  = in_data_i.side;
          qty_d   = in_data_i.quantity;
          price_d = AW'(in_data_i.price);
          if (in_data_i.command == lobm_pkg::CMD_CLEAR) begin
            bbest_d    = '0;
            abest_d    = '0;
            bpres_d    = 1'b0;
            apres_d    = 1'b0;
            ltrade_d   = '0;
            tseen_d    = 1'b0;
            res_pend_d = 1'b1;
            clr_cnt_d  = '0;
            state_d    = S_CLR;
          end else if (in_ok) begin
            state_d = S_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD: state_d = S_ADD;
      S_ADD: begin
        if (side_q == lobm_pkg::SIDE_BUY) begin
          if (!bpres_q || price_q > bbest_q) begin
            bpres_d = 1'b1;
            bbest_d = price_q;
          end
        end else begin
          if (!apres_q || price_q < abest_q) begin
            apres_d = 1'b1;
            abest_d = price_q;
          end
        end
        state_d = S_MCHK;
      end
      S_MCHK: begin
        state_d = (bpres_q && apres_q && bbest_q >= abest_q) ? S_TRADE : S_DONE;
      end
      S_TRADE: begin
        ltrade_d = abest_q;
        tseen_d  = 1'b1;
        ascan_d  = (ask_left == '0);
        if (bid_left == '0) begin
          state_d = S_BRD;
        end else if (ask_left == '0) begin
          state_d = S_ARD;
        end else begin
          state_d = S_MCHK;
        end
      end
      S_BRD: state_d = S_BCK;
      S_BCK: begin
        // everything above the old best is empty, so walk down from it
        if (bid_rdata != '0) begin
          state_d = ascan_q ? S_ARD : S_MCHK;
        end else if (bbest_q == '0) begin
          bpres_d = 1'b0;
          state_d = ascan_q ? S_ARD : S_MCHK;
        end else begin
          bbest_d = bbest_q - 1'b1;
          state_d = S_BRD;
        end
      end
      S_ARD: state_d = S_ACK;
      S_ACK: begin
        ascan_d = 1'b0;
        if (ask_rdata != '0) begin
          state_d = S_MCHK;
        end else if (abest_q == LastLevel) begin
          apres_d = 1'b0;
          abest_d = '0;
          state_d = S_MCHK;
        end else begin
          abest_d = abest_q + 1'b1;
          state_d = S_ARD;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d                 = 1'b1;
          res_pend_d               = 1'b0;
          odata_d.best_ask         = apres_q ? 10'(abest_q) : 10'd0;
          odata_d.ask_valid        = apres_q;
          odata_d.best_bid         = bpres_q ? 10'(bbest_q) : 10'd0;
          odata_d.bid_valid        = bpres_q;
          odata_d.last_trade_price = tseen_q ? 10'(ltrade_q) : 10'd0;
          odata_d.trade_valid      = tseen_q;
          state_d                  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_cnt_q  <= '0;
      res_pend_q <= 1'b0;
      bbest_q    <= '0;
      abest_q    <= '0;
      bpres_q    <= 1'b0;
      apres_q    <= 1'b0;
      ltrade_q   <= '0;
      tseen_q    <= 1'b0;
      ascan_q    <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      res_pend_q <= res_pend_d;
      bbest_q    <= bbest_d;
      abest_q    <= abest_d;
      bpres_q    <= bpres_d;
      apres_q    <= apres_d;
      ltrade_q   <= ltrade_d;
      tseen_q    <= tseen_d;
      ascan_q    <= ascan_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q  <= side_d;
    qty_q   <= qty_d;
    price_q <= price_d;
    odata_q <= odata_d;
  end

endmodule

// ----- hw/rtl/lobm_ram.sv -----
module lobm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LEVELS     = 1024;
  localparam int  QTY_BITS   = 32;
  localparam logic SIDE_SELL = ~lobm_pkg::SIDE_BUY;
  // Worst place beat: a full-depth rescan on both sides, plus receiver
  // stalls. Taken several times over for ~1500 beats.
  localparam int  LIMIT_CYCLES = 8_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lobm_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lobm_pkg::out_t out_data;

  // Idle / stall odds in percent, changed per phase
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned errors = 0;

  // Shadow of the two books and the top-of-book registers
  logic [QTY_BITS-1:0] bid_qty [LEVELS];
  logic [QTY_BITS-1:0] ask_qty [LEVELS];
  logic [9:0] top_bid, top_ask, last_px;
  logic       has_bid, has_ask, traded;

  lobm_pkg::out_t book_expected [$];

  limit_order_book_matcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // --- book shadow ---------------------------------------------------------
  function automatic void wipe_book();
    for (int p = 0; p < LEVELS; p++) begin
      bid_qty[p] = '0;
      ask_qty[p] = '0;
    end
    top_bid = '0; top_ask = '0; last_px = '0;
    has_bid = 1'b0; has_ask = 1'b0; traded = 1'b0;
  endfunction

  function automatic void rescan_bid();
    has_bid = 1'b0;
    top_bid = '0;
    for (int p = LEVELS - 1; p >= 0; p--) begin
      if (bid_qty[p] != '0) begin
        has_bid = 1'b1;
        top_bid = p[9:0];
        break;
      end
    end
  endfunction

  function automatic void rescan_ask();
    has_ask = 1'b0;
    top_ask = '0;
    for (int p = 0; p < LEVELS; p++) begin
      if (ask_qty[p] != '0) begin
        has_ask = 1'b1;
        top_ask = p[9:0];
        break;
      end
    end
  endfunction

  // Saturating add into a level total
  function automatic logic [QTY_BITS-1:0] sat_add(input logic [QTY_BITS-1:0] lvl,
                                                  input logic [15:0] q);
    logic [QTY_BITS:0] sum;
    sum = {1'b0, lvl} + (QTY_BITS + 1)'(q);
    return sum[QTY_BITS] ? {QTY_BITS{1'b1}} : sum[QTY_BITS-1:0];
  endfunction

  function automatic lobm_pkg::out_t book_after(input lobm_pkg::in_t beat);
    logic [QTY_BITS-1:0] fill;
    lobm_pkg::out_t r;
    if (beat.command == lobm_pkg::CMD_CLEAR) begin
      wipe_book();
    end else if (beat.quantity != '0) begin
      if (beat.side == lobm_pkg::SIDE_BUY) begin
        bid_qty[beat.price] = sat_add(bid_qty[beat.price], beat.quantity);
        if (!has_bid || beat.price > top_bid) begin
          has_bid = 1'b1;
          top_bid = beat.price;
        end
      end else begin
        ask_qty[beat.price] = sat_add(ask_qty[beat.price], beat.quantity);
        if (!has_ask || beat.price < top_ask) begin
          has_ask = 1'b1;
          top_ask = beat.price;
        end
      end
      // cross while the book is locked or crossed; trades print at the ask
      while (has_bid && has_ask && top_bid >= top_ask) begin
        fill = (bid_qty[top_bid] < ask_qty[top_ask]) ? bid_qty[top_bid] : ask_qty[top_ask];
        last_px = top_ask;
        traded  = 1'b1;
        bid_qty[top_bid] -= fill;
        ask_qty[top_ask] -= fill;
        if (bid_qty[top_bid] == '0) rescan_bid();
        if (ask_qty[top_ask] == '0) rescan_ask();
      end
    end
    r.best_ask         = has_ask ? top_ask : '0;
    r.ask_valid        = has_ask;
    r.best_bid         = has_bid ? top_bid : '0;
    r.bid_valid        = has_bid;
    r.last_trade_price = traded ? last_px : '0;
    r.trade_valid      = traded;
    return r;
  endfunction

  // --- input side ----------------------------------------------------------
  task automatic send_beat(input logic cmd, input logic sd, input logic [15:0] q,
                           input logic [9:0] px);
    lobm_pkg::in_t beat;
    int unsigned gap;
    beat.command  = cmd;
    beat.side     = sd;
    beat.quantity = q;
    beat.price    = px;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct && gap < 8) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (!in_ready);
    book_expected.insert(book_expected.size(), book_after(beat));
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    hold_input();
    while (book_expected.size() != 0) @(posedge clk_i);
  endtask

  // --- output side ---------------------------------------------------------
  always @(posedge clk_i) begin
    lobm_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (book_expected.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          want = book_expected.pop_front();
          if (out_data.best_ask != want.best_ask)
            report("best_ask", int'(out_data.best_ask), int'(want.best_ask));
          if (out_data.ask_valid != want.ask_valid)
            report("ask_valid", int'(out_data.ask_valid), int'(want.ask_valid));
          if (out_data.best_bid != want.best_bid)
            report("best_bid", int'(out_data.best_bid), int'(want.best_bid));
          if (out_data.bid_valid != want.bid_valid)
            report("bid_valid", int'(out_data.bid_valid), int'(want.bid_valid));
          if (out_data.last_trade_price != want.last_trade_price)
            report("last_trade_price", int'(out_data.last_trade_price),
                   int'(want.last_trade_price));
          if (out_data.trade_valid != want.trade_valid)
            report("trade_valid", int'(out_data.trade_valid), int'(want.trade_valid));
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // --- tests ---------------------------------------------------------------
  // Price and quantity extremes, zero quantity, clear, multi-level sweeps
  task automatic test_directed();
    send_beat(lobm_pkg::CMD_CLEAR, lobm_pkg::SIDE_BUY, 16'hFFFF, 10'h3FF);
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd1, 10'd0);
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'hFFFF, 10'd1023);
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'hFFFF, 10'd1023); // exact fill
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd0, 10'd500);     // adds no level
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'd0, 10'd0);
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'd1, 10'd0);                // locked at 0
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd100, 10'd600);
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd50, 10'd700);
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'd120, 10'd650);            // fills bid at 700, rest rests
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'd200, 10'd500);            // walks into 600
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd10, 10'd300);
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd10, 10'd299);
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd10, 10'd1);
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'hFFFF, 10'd0);             // sweeps bids
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'h8000, 10'd1023);
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'h7FFF, 10'd512);
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'h5555, 10'd341);
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'hAAAA, 10'd682);
    send_beat(lobm_pkg::CMD_CLEAR, SIDE_SELL, 16'd0, 10'd0);
    send_beat(lobm_pkg::CMD_PLACE, SIDE_SELL, 16'd7, 10'd1023);
    send_beat(lobm_pkg::CMD_PLACE, lobm_pkg::SIDE_BUY, 16'd7, 10'd0);
    drain_results();
  endtask

  // Orders clustered round a drifting mid so the books cross often and stay
  // shallow; a few wide prices, odd sizes and clears mixed in.
  task automatic test_random(input int unsigned n, input int unsigned idle,
                             input int unsigned stall);
    int unsigned mid, roll;
    logic [15:0] q;
    logic [9:0] px;
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    mid = $urandom_range(900, 100);
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_beat(lobm_pkg::CMD_CLEAR, 1'($urandom_range(1)), 16'($urandom), 10'($urandom));
        mid = $urandom_range(900, 100);
      end else begin
        if ($urandom_range(99) < 5) mid = $urandom_range(900, 100);
        px = (roll < 8) ? 10'($urandom) : 10'(mid + $urandom_range(24) - 12);
        case ($urandom_range(19))
          0:       q = 16'($urandom);
          1:       q = 16'hFFFF;
          2:       q = 16'd0;
          default: q = 16'($urandom_range(200, 1));
        endcase
        send_beat(lobm_pkg::CMD_PLACE, 1'($urandom_range(1)), q, px);
      end
    end
    drain_results();
  endtask

  initial begin
    wipe_book();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(375, 0, 0);
    test_random(375, 55, 0);
    test_random(375, 0, 55);
    test_random(375, 10, 10);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
